>>> rtl/gzfs_pkg.sv
// Shared widths, codes and record types of the grouped zone fire sequencer.
package gzfs_pkg;

    localparam int ZONE_COUNT_DEF = 16;

    localparam int KIND_W    = 3;
    localparam int ZIDX_W    = 4;
    localparam int ORDER_W   = 8;
    localparam int GROUP_W   = 8;
    localparam int TIME_W    = 20;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int EVENT_W   = 3;
    localparam int MASK_W    = 16;
    localparam int STEP_W    = 5;
    localparam int STATUS_W  = 2;
    localparam int ELAPSED_W = 21;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [EVENT_W-1:0]   event_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_ZONE_WRITE = 3'd0;
    localparam kind_t KIND_START      = 3'd1;
    localparam kind_t KIND_TICK       = 3'd2;
    localparam kind_t KIND_ABORT      = 3'd3;
    localparam kind_t KIND_STOP       = 3'd4;

    localparam event_t EV_NONE      = 3'd0;
    localparam event_t EV_FIRE      = 3'd1;
    localparam event_t EV_COMPLETE  = 3'd2;
    localparam event_t EV_ABORTED   = 3'd3;
    localparam event_t EV_STOPPED   = 3'd4;
    localparam event_t EV_NOT_ARMED = 3'd5;
    localparam event_t EV_EMPTY     = 3'd6;
    localparam event_t EV_NO_TIME   = 3'd7;

    localparam cfg_idx_t CFG_AUTO_DELAY = 2'd0;
    localparam cfg_idx_t CFG_IGNITER_ON = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_ABORTED = 2'd2
    } mode_t;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [GROUP_W-1:0] group;
        logic [TIME_W-1:0]  time_ms;
    } zone_rec_t;

endpackage

>>> rtl/gzfs_req_if.sv
// Input item channel of the grouped zone fire sequencer.
interface gzfs_req_if;
    logic                         valid;
    logic                         ready;
    logic [gzfs_pkg::KIND_W-1:0]  kind;
    logic [gzfs_pkg::ZIDX_W-1:0]  zone_index;
    logic                         zone_enable;
    logic [gzfs_pkg::ORDER_W-1:0] zone_order;
    logic [gzfs_pkg::GROUP_W-1:0] zone_group;
    logic [gzfs_pkg::TIME_W-1:0]  zone_time_ms;
    logic                         master_armed;

    modport source (output valid, kind, zone_index, zone_enable, zone_order, zone_group,
                    zone_time_ms, master_armed, input ready);
    modport sink (input valid, kind, zone_index, zone_enable, zone_order, zone_group,
                  zone_time_ms, master_armed, output ready);
endinterface

>>> rtl/gzfs_rsp_if.sv
// Result item channel of the grouped zone fire sequencer.
interface gzfs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gzfs_pkg::EVENT_W-1:0]  event_res;
    logic [gzfs_pkg::MASK_W-1:0]   fire_mask;
    logic [gzfs_pkg::ZIDX_W-1:0]   first_zone;
    logic [gzfs_pkg::STEP_W-1:0]   step_number;
    logic [gzfs_pkg::STEP_W-1:0]   total_steps;
    logic [gzfs_pkg::TIME_W-1:0]   step_duration_ms;
    logic [gzfs_pkg::CFG_W-1:0]    igniter_time_ms;
    logic                          disarm;
    logic [gzfs_pkg::STATUS_W-1:0] run_status;

    modport source (output valid, event_res, fire_mask, first_zone, step_number, total_steps,
                    step_duration_ms, igniter_time_ms, disarm, run_status, input ready);
    modport sink (input valid, event_res, fire_mask, first_zone, step_number, total_steps,
                  step_duration_ms, igniter_time_ms, disarm, run_status, output ready);
endinterface

>>> rtl/gzfs_cfg_if.sv
// Configuration write channel of the grouped zone fire sequencer.
interface gzfs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gzfs_pkg::CFG_IDX_W-1:0] index;
    logic [gzfs_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gzfs_zone_store.sv
// Zone table: enable bits in flops, order/group/time in a one-port-read memory.
module gzfs_zone_store #(
    parameter int ZONE_COUNT = gzfs_pkg::ZONE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(ZONE_COUNT)-1:0]   wr_addr,
    input  logic                            wr_enable,
    input  gzfs_pkg::zone_rec_t             wr_rec,
    input  logic [$clog2(ZONE_COUNT)-1:0]   rd_addr,
    output gzfs_pkg::zone_rec_t             rd_rec,
    output logic                            rd_enable
);

    logic [ZONE_COUNT-1:0] enable_reg;
    gzfs_pkg::zone_rec_t   mem [ZONE_COUNT];
    gzfs_pkg::zone_rec_t   rd_rec_reg;
    logic                  rd_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (wr_en)
        begin
            enable_reg[wr_addr] <= wr_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        rd_rec_reg    <= mem[rd_addr];
        rd_enable_reg <= enable_reg[rd_addr];
    end

    assign rd_rec    = rd_rec_reg;
    assign rd_enable = rd_enable_reg;

endmodule

>>> rtl/gzfs_step_store.sv
// Step queue memory: fire mask, duration and lead zone per step.
module gzfs_step_store #(
    parameter int ZONE_COUNT = gzfs_pkg::ZONE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(ZONE_COUNT)-1:0]   wr_addr,
    input  logic [ZONE_COUNT-1:0]           wr_mask,
    input  logic [gzfs_pkg::TIME_W-1:0]     wr_time,
    input  logic [$clog2(ZONE_COUNT)-1:0]   wr_lead,
    input  logic [$clog2(ZONE_COUNT)-1:0]   rd_addr,
    output logic [ZONE_COUNT-1:0]           rd_mask,
    output logic [gzfs_pkg::TIME_W-1:0]     rd_time,
    output logic [$clog2(ZONE_COUNT)-1:0]   rd_lead
);

    localparam int ZAW = $clog2(ZONE_COUNT);

    logic [ZONE_COUNT-1:0]       mask_mem [ZONE_COUNT];
    logic [gzfs_pkg::TIME_W-1:0] time_mem [ZONE_COUNT];
    logic [ZAW-1:0]              lead_mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0]       rd_mask_reg;
    logic [gzfs_pkg::TIME_W-1:0] rd_time_reg;
    logic [ZAW-1:0]              rd_lead_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mask_mem[wr_addr] <= wr_mask;
            time_mem[wr_addr] <= wr_time;
            lead_mem[wr_addr] <= wr_lead;
        end
        rd_mask_reg <= mask_mem[rd_addr];
        rd_time_reg <= time_mem[rd_addr];
        rd_lead_reg <= lead_mem[rd_addr];
    end

    assign rd_mask = rd_mask_reg;
    assign rd_time = rd_time_reg;
    assign rd_lead = rd_lead_reg;

endmodule

>>> rtl/grouped_zone_fire_sequencer.sv
// Zone write, abort, stop and idle ticks go from idle to emit; a tick checking a step goes
// through the tick check and, on advance, the fire read. Start scans the zone memory once
// per step lead, per group and at the end, reading every zone in turn by the one read port.
// Throughput: one item at a time; the next item is taken while the result waits to be taken.
// Reset clears the enable bits, counters, mode and registers; the step queue is not cleared.
module grouped_zone_fire_sequencer #(
    parameter int ZONE_COUNT = gzfs_pkg::ZONE_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gzfs_req_if.sink     req,
    gzfs_rsp_if.source   rsp,
    gzfs_cfg_if.sink     cfg
);

    localparam int ZAW = $clog2(ZONE_COUNT);
    localparam int CW  = $clog2(ZONE_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_GROUP,
        S_TICK_CHK,
        S_FIRE_RD,
        S_EMIT
    } state_t;

    state_t                         state_reg;
    gzfs_pkg::mode_t                mode_reg;
    logic [CW-1:0]                  step_count_reg;
    logic [CW-1:0]                  cur_reg;
    logic [gzfs_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [gzfs_pkg::CFG_W-1:0]     auto_delay_reg;
    logic [gzfs_pkg::CFG_W-1:0]     igniter_reg;

    // build scan state
    logic [CW-1:0]                  scan_reg;
    logic                           rd_valid_reg;
    logic [ZAW-1:0]                 rd_idx_reg;
    logic [ZONE_COUNT-1:0]          used_reg;
    logic                           bad_reg;
    logic [CW-1:0]                  bcount_reg;
    logic                           best_found_reg;
    logic [ZAW-1:0]                 best_idx_reg;
    logic [gzfs_pkg::ORDER_W-1:0]   best_order_reg;
    logic [gzfs_pkg::GROUP_W-1:0]   best_group_reg;
    logic [gzfs_pkg::TIME_W-1:0]    best_time_reg;
    logic [ZONE_COUNT-1:0]          grp_mask_reg;
    logic [gzfs_pkg::TIME_W-1:0]    grp_time_reg;

    // pending result
    gzfs_pkg::event_t               res_event_reg;
    logic [gzfs_pkg::MASK_W-1:0]    res_mask_reg;
    logic [gzfs_pkg::ZIDX_W-1:0]    res_lead_reg;
    logic [gzfs_pkg::STEP_W-1:0]    res_num_reg;
    logic [gzfs_pkg::STEP_W-1:0]    res_total_reg;
    logic [gzfs_pkg::TIME_W-1:0]    res_dur_reg;
    logic [gzfs_pkg::CFG_W-1:0]     res_igniter_reg;
    logic                           res_disarm_reg;

    // output slot
    logic                           out_valid_reg;
    gzfs_pkg::event_t               out_event_reg;
    logic [gzfs_pkg::MASK_W-1:0]    out_mask_reg;
    logic [gzfs_pkg::ZIDX_W-1:0]    out_lead_reg;
    logic [gzfs_pkg::STEP_W-1:0]    out_num_reg;
    logic [gzfs_pkg::STEP_W-1:0]    out_total_reg;
    logic [gzfs_pkg::TIME_W-1:0]    out_dur_reg;
    logic [gzfs_pkg::CFG_W-1:0]     out_igniter_reg;
    logic                           out_disarm_reg;
    logic [gzfs_pkg::STATUS_W-1:0]  out_status_reg;

    // memory-side signals
    logic                           in_fire;
    logic                           scanning;
    logic                           issue;
    logic                           scan_done;
    logic                           zone_wr_en;
    gzfs_pkg::zone_rec_t            zone_wr_rec;
    gzfs_pkg::zone_rec_t            e_rec;
    logic                           e_en;
    logic                           e_used;
    logic                           e_cand;
    logic [ZONE_COUNT-1:0]          e_bit;
    logic [ZONE_COUNT-1:0]          best_bit;
    logic                           step_wr_en;
    logic [ZONE_COUNT-1:0]          step_wr_mask;
    logic [gzfs_pkg::TIME_W-1:0]    step_wr_time;
    logic [ZAW-1:0]                 step_rd_addr;
    logic [ZONE_COUNT-1:0]          step_rd_mask;
    logic [gzfs_pkg::TIME_W-1:0]    step_rd_time;
    logic [ZAW-1:0]                 step_rd_lead;
    logic [CW-1:0]                  cur_plus;
    logic [gzfs_pkg::ELAPSED_W-1:0] need_ms;
    logic                           load_out;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign in_fire   = req.valid && req.ready;

    // Zone writes go straight into the zone store; out-of-range indexes are dropped.
    assign zone_wr_en = in_fire && (req.kind == gzfs_pkg::KIND_ZONE_WRITE)
                        && (int'(req.zone_index) < ZONE_COUNT);
    assign zone_wr_rec = '{order: req.zone_order, group: req.zone_group,
                           time_ms: req.zone_time_ms};

    // One zone entry is read per cycle during a scan; its data returns in the next cycle.
    assign scanning  = (state_reg == S_FIND) || (state_reg == S_GROUP);
    assign issue     = scanning && (int'(scan_reg) < ZONE_COUNT);
    assign scan_done = scanning && !issue && !rd_valid_reg;

    assign e_used   = used_reg[rd_idx_reg];
    assign e_cand   = e_en && (e_rec.time_ms != '0) && !e_used;
    assign e_bit    = ZONE_COUNT'(1) << rd_idx_reg;
    assign best_bit = ZONE_COUNT'(1) << best_idx_reg;

    // Write a step at the end of a lead scan (ungrouped zone) or of a group scan.
    always_comb
    begin
        step_wr_en   = 1'b0;
        step_wr_mask = best_bit;
        step_wr_time = best_time_reg;
        if (scan_done && (state_reg == S_FIND) && best_found_reg && (best_group_reg == '0))
        begin
            step_wr_en = 1'b1;
        end
        else if (scan_done && (state_reg == S_GROUP))
        begin
            step_wr_en   = 1'b1;
            step_wr_mask = grp_mask_reg;
            step_wr_time = grp_time_reg;
        end
    end

    assign cur_plus = cur_reg + CW'(1);
    assign need_ms  = gzfs_pkg::ELAPSED_W'(step_rd_time) + gzfs_pkg::ELAPSED_W'(auto_delay_reg);

    // Step read address: current step for a tick, next step on advance, step 0 on start.
    always_comb
    begin
        unique case (state_reg)
            S_TICK_CHK: step_rd_addr = cur_plus[ZAW-1:0];
            S_FIND:     step_rd_addr = '0;
            default:    step_rd_addr = cur_reg[ZAW-1:0];
        endcase
    end

    assign load_out = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    gzfs_zone_store #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_zone_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (zone_wr_en),
        .wr_addr   (ZAW'(req.zone_index)),
        .wr_enable (req.zone_enable),
        .wr_rec    (zone_wr_rec),
        .rd_addr   (ZAW'(scan_reg)),
        .rd_rec    (e_rec),
        .rd_enable (e_en)
    );

    gzfs_step_store #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_step_store (
        .clk     (clk),
        .wr_en   (step_wr_en),
        .wr_addr (bcount_reg[ZAW-1:0]),
        .wr_mask (step_wr_mask),
        .wr_time (step_wr_time),
        .wr_lead (best_idx_reg),
        .rd_addr (step_rd_addr),
        .rd_mask (step_rd_mask),
        .rd_time (step_rd_time),
        .rd_lead (step_rd_lead)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= gzfs_pkg::MODE_IDLE;
            step_count_reg  <= '0;
            cur_reg         <= '0;
            elapsed_reg     <= '0;
            auto_delay_reg  <= '0;
            igniter_reg     <= '0;
            scan_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            used_reg        <= '0;
            bad_reg         <= 1'b0;
            bcount_reg      <= '0;
            best_found_reg  <= 1'b0;
            best_idx_reg    <= '0;
            best_order_reg  <= '0;
            best_group_reg  <= '0;
            best_time_reg   <= '0;
            grp_mask_reg    <= '0;
            grp_time_reg    <= '0;
            res_event_reg   <= gzfs_pkg::EV_NONE;
            res_mask_reg    <= '0;
            res_lead_reg    <= '0;
            res_num_reg     <= '0;
            res_total_reg   <= '0;
            res_dur_reg     <= '0;
            res_igniter_reg <= '0;
            res_disarm_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_event_reg   <= gzfs_pkg::EV_NONE;
            out_mask_reg    <= '0;
            out_lead_reg    <= '0;
            out_num_reg     <= '0;
            out_total_reg   <= '0;
            out_dur_reg     <= '0;
            out_igniter_reg <= '0;
            out_disarm_reg  <= 1'b0;
            out_status_reg  <= '0;
        end
        else
        begin
            // Configuration writes; unknown indexes are ignored.
            if (cfg.valid)
            begin
                if (cfg.index == gzfs_pkg::CFG_AUTO_DELAY)
                begin
                    auto_delay_reg <= cfg.data;
                end
                else if (cfg.index == gzfs_pkg::CFG_IGNITER_ON)
                begin
                    igniter_reg <= cfg.data;
                end
            end

            // The output slot empties when taken and refills from the pending result.
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg   <= 1'b1;
                out_event_reg   <= res_event_reg;
                out_mask_reg    <= res_mask_reg;
                out_lead_reg    <= res_lead_reg;
                out_num_reg     <= res_num_reg;
                out_total_reg   <= res_total_reg;
                out_dur_reg     <= res_dur_reg;
                out_igniter_reg <= res_igniter_reg;
                out_disarm_reg  <= res_disarm_reg;
                out_status_reg  <= mode_reg;
            end

            // Scan pipeline: track which entry comes back from the zone store.
            rd_valid_reg <= issue;
            rd_idx_reg   <= ZAW'(scan_reg);
            if (issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_event_reg   <= gzfs_pkg::EV_NONE;
                        res_mask_reg    <= '0;
                        res_lead_reg    <= '0;
                        res_num_reg     <= '0;
                        res_total_reg   <= '0;
                        res_dur_reg     <= '0;
                        res_igniter_reg <= '0;
                        res_disarm_reg  <= 1'b0;
                        state_reg       <= S_EMIT;
                        priority if (req.kind == gzfs_pkg::KIND_START)
                        begin
                            if (!req.master_armed)
                            begin
                                res_event_reg <= gzfs_pkg::EV_NOT_ARMED;
                            end
                            else
                            begin
                                // Rebuild the queue from scratch.
                                used_reg       <= '0;
                                bad_reg        <= 1'b0;
                                bcount_reg     <= '0;
                                scan_reg       <= '0;
                                best_found_reg <= 1'b0;
                                state_reg      <= S_FIND;
                            end
                        end
                        else if (req.kind == gzfs_pkg::KIND_TICK)
                        begin
                            if (mode_reg == gzfs_pkg::MODE_RUNNING)
                            begin
                                if (elapsed_reg != '1)
                                begin
                                    elapsed_reg <= elapsed_reg + gzfs_pkg::ELAPSED_W'(1);
                                end
                                if (cur_reg >= step_count_reg)
                                begin
                                    mode_reg       <= gzfs_pkg::MODE_IDLE;
                                    cur_reg        <= '0;
                                    step_count_reg <= '0;
                                    res_event_reg  <= gzfs_pkg::EV_COMPLETE;
                                end
                                else
                                begin
                                    state_reg <= S_TICK_CHK;
                                end
                            end
                        end
                        else if (req.kind == gzfs_pkg::KIND_ABORT)
                        begin
                            if (mode_reg == gzfs_pkg::MODE_RUNNING)
                            begin
                                mode_reg       <= gzfs_pkg::MODE_ABORTED;
                                cur_reg        <= '0;
                                step_count_reg <= '0;
                                res_event_reg  <= gzfs_pkg::EV_ABORTED;
                                res_disarm_reg <= 1'b1;
                            end
                        end
                        else if (req.kind == gzfs_pkg::KIND_STOP)
                        begin
                            if (mode_reg == gzfs_pkg::MODE_RUNNING)
                            begin
                                mode_reg       <= gzfs_pkg::MODE_IDLE;
                                cur_reg        <= '0;
                                step_count_reg <= '0;
                                res_event_reg  <= gzfs_pkg::EV_STOPPED;
                            end
                        end
                        else
                        begin
                            // Zone writes and unknown kinds report none.
                        end
                    end
                end

                S_FIND:
                begin
                    // Pick the lowest order among unused timed zones; ties keep lower index.
                    if (rd_valid_reg)
                    begin
                        if (e_en && (e_rec.time_ms == '0))
                        begin
                            bad_reg <= 1'b1;
                        end
                        if (e_cand && (!best_found_reg || (e_rec.order < best_order_reg)))
                        begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= rd_idx_reg;
                            best_order_reg <= e_rec.order;
                            best_group_reg <= e_rec.group;
                            best_time_reg  <= e_rec.time_ms;
                        end
                    end
                    if (scan_done)
                    begin
                        scan_reg       <= '0;
                        best_found_reg <= 1'b0;
                        if (best_found_reg)
                        begin
                            if (best_group_reg == '0)
                            begin
                                used_reg   <= used_reg | best_bit;
                                bcount_reg <= bcount_reg + CW'(1);
                            end
                            else
                            begin
                                best_found_reg <= 1'b1;
                                grp_mask_reg   <= '0;
                                grp_time_reg   <= best_time_reg;
                                state_reg      <= S_GROUP;
                            end
                        end
                        else
                        begin
                            // Queue built: commit the count, then check it.
                            step_count_reg <= bcount_reg;
                            if (bcount_reg == '0)
                            begin
                                res_event_reg <= gzfs_pkg::EV_EMPTY;
                                state_reg     <= S_EMIT;
                            end
                            else if (bad_reg)
                            begin
                                res_event_reg <= gzfs_pkg::EV_NO_TIME;
                                state_reg     <= S_EMIT;
                            end
                            else
                            begin
                                mode_reg    <= gzfs_pkg::MODE_RUNNING;
                                cur_reg     <= '0;
                                elapsed_reg <= '0;
                                state_reg   <= S_FIRE_RD;
                            end
                        end
                    end
                end

                S_GROUP:
                begin
                    // Gather every unused timed member of the lead's group, keep longest time.
                    if (rd_valid_reg && e_cand && (e_rec.group == best_group_reg))
                    begin
                        grp_mask_reg <= grp_mask_reg | e_bit;
                        if (e_rec.time_ms > grp_time_reg)
                        begin
                            grp_time_reg <= e_rec.time_ms;
                        end
                    end
                    if (scan_done)
                    begin
                        used_reg       <= used_reg | grp_mask_reg;
                        bcount_reg     <= bcount_reg + CW'(1);
                        scan_reg       <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= S_FIND;
                    end
                end

                S_TICK_CHK:
                begin
                    // Once the step time plus the auto delay has gone by, advance, or complete after the last step.
                    state_reg <= S_EMIT;
                    if (elapsed_reg >= need_ms)
                    begin
                        if (cur_plus >= step_count_reg)
                        begin
                            mode_reg       <= gzfs_pkg::MODE_IDLE;
                            cur_reg        <= '0;
                            step_count_reg <= '0;
                            res_event_reg  <= gzfs_pkg::EV_COMPLETE;
                        end
                        else
                        begin
                            cur_reg     <= cur_plus;
                            elapsed_reg <= '0;
                            state_reg   <= S_FIRE_RD;
                        end
                    end
                end

                S_FIRE_RD:
                begin
                    // Step data for cur_reg is on the store output now.
                    res_event_reg   <= gzfs_pkg::EV_FIRE;
                    res_mask_reg    <= gzfs_pkg::MASK_W'(step_rd_mask);
                    res_lead_reg    <= gzfs_pkg::ZIDX_W'(step_rd_lead);
                    res_num_reg     <= gzfs_pkg::STEP_W'(cur_reg) + gzfs_pkg::STEP_W'(1);
                    res_total_reg   <= gzfs_pkg::STEP_W'(step_count_reg);
                    res_dur_reg     <= (step_rd_time == '0) ? gzfs_pkg::TIME_W'(1)
                                                            : step_rd_time;
                    res_igniter_reg <= igniter_reg;
                    state_reg       <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.event_res        = out_event_reg;
    assign rsp.fire_mask        = out_mask_reg;
    assign rsp.first_zone       = out_lead_reg;
    assign rsp.step_number      = out_num_reg;
    assign rsp.total_steps      = out_total_reg;
    assign rsp.step_duration_ms = out_dur_reg;
    assign rsp.igniter_time_ms  = out_igniter_reg;
    assign rsp.disarm           = out_disarm_reg;
    assign rsp.run_status       = out_status_reg;

    // An accepted item always moves the state out of idle in the following cycle.
    a_item_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // A fired step is numbered inside the queue and lasts at least one ms.
    a_fire_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.event_res == gzfs_pkg::EV_FIRE)) |->
        ((rsp.step_number != '0) && (rsp.step_number <= rsp.total_steps)
         && (rsp.step_duration_ms != '0)))
        else $error("fire result outside the step queue");

    // Disarm comes with an abort, and an abort leaves the aborted status.
    a_disarm_on_abort: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.disarm == (rsp.event_res == gzfs_pkg::EV_ABORTED))
        && (!rsp.disarm || (rsp.run_status == gzfs_pkg::MODE_ABORTED))))
        else $error("disarm does not match abort");

endmodule

>>> bench/gzfs_tb_types.sv
// Testbench record types for one input item and one result of the zone fire sequencer.
`timescale 1ns / 1ps
package gzfs_tb_types;
    import gzfs_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ZIDX_W-1:0]  zone_index;
        logic               zone_enable;
        logic [ORDER_W-1:0] zone_order;
        logic [GROUP_W-1:0] zone_group;
        logic [TIME_W-1:0]  zone_time_ms;
        logic               master_armed;
    } cmd_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [MASK_W-1:0]   fire_mask;
        logic [ZIDX_W-1:0]   first_zone;
        logic [STEP_W-1:0]   step_number;
        logic [STEP_W-1:0]   total_steps;
        logic [TIME_W-1:0]   step_duration_ms;
        logic [CFG_W-1:0]    igniter_time_ms;
        logic                disarm;
        logic [STATUS_W-1:0] run_status;
    } outcome_t;
endpackage

>>> bench/testbench.sv
// Top-level testbench: drives zone, start, tick, abort and stop items and checks every result.
`timescale 1ns / 1ps
module testbench;
    import gzfs_pkg::*;
    import gzfs_tb_types::*;

    localparam int NZ        = 16;
    localparam int MAX_CYCLE = 3000000;
    localparam int TAIL      = 20;
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

    logic clk;
    logic rst_n;

    gzfs_req_if req ();
    gzfs_rsp_if rsp ();
    gzfs_cfg_if cfg ();

    grouped_zone_fire_sequencer #(.ZONE_COUNT(NZ)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the sequencer's state, updated as each item is accepted.
    logic [15:0]          sh_enabled;
    logic [ORDER_W-1:0]   sh_order [NZ];
    logic [GROUP_W-1:0]   sh_group [NZ];
    logic [TIME_W-1:0]    sh_time  [NZ];
    logic [MASK_W-1:0]    sh_step_mask [NZ];
    logic [TIME_W-1:0]    sh_step_time [NZ];
    logic [ZIDX_W-1:0]    sh_step_lead [NZ];
    logic [STEP_W-1:0]    sh_step_count;
    logic [STEP_W-1:0]    sh_cur_step;
    logic [ELAPSED_W-1:0] sh_elapsed;
    mode_t                sh_mode;
    logic [CFG_W-1:0]     sh_auto_delay;
    logic [CFG_W-1:0]     sh_igniter_on;

    cmd_t     pending_cmds [$];
    outcome_t awaited [$];
    int       fail_count;
    int       cycle_count;
    bit       cfg_busy;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sort enabled zones by order (stable on index), then merge groups into steps.
    function automatic void rebuild_queue();
        int          list [NZ];
        bit          taken [NZ];
        int          n;
        int          k;
        int          z;
        int          s;
        logic [MASK_W-1:0] m;
        logic [TIME_W-1:0] t;
        n = 0;
        for (int i = 0; i < NZ; i++)
        begin
            if (sh_enabled[i])
            begin
                k = n;
                while (k > 0 && sh_order[list[k-1]] > sh_order[i])
                begin
                    list[k] = list[k-1];
                    k--;
                end
                list[k] = i;
                n++;
            end
        end
        for (int i = 0; i < NZ; i++)
            taken[i] = 1'b0;
        sh_step_count = '0;
        for (k = 0; k < n; k++)
        begin
            z = list[k];
            if (taken[z] || sh_time[z] == '0)
                continue;
            if (sh_group[z] != '0)
            begin
                m = '0;
                t = sh_time[z];
                for (int j = 0; j < n; j++)
                begin
                    s = list[j];
                    if (taken[s] || sh_group[s] != sh_group[z] || sh_time[s] == '0)
                        continue;
                    m[s] = 1'b1;
                    taken[s] = 1'b1;
                    if (sh_time[s] > t)
                        t = sh_time[s];
                end
            end
            else
            begin
                taken[z] = 1'b1;
                m = '0;
                m[z] = 1'b1;
                t = sh_time[z];
            end
            sh_step_mask[sh_step_count] = m;
            sh_step_time[sh_step_count] = t;
            sh_step_lead[sh_step_count] = z[ZIDX_W-1:0];
            sh_step_count++;
        end
    endfunction

    function automatic void fill_fire(inout outcome_t o);
        o.event_res        = EV_FIRE;
        o.fire_mask        = sh_step_mask[sh_cur_step];
        o.first_zone       = sh_step_lead[sh_cur_step];
        o.step_number      = sh_cur_step + 5'd1;
        o.total_steps      = sh_step_count;
        o.step_duration_ms = (sh_step_time[sh_cur_step] == '0) ? 20'd1 : sh_step_time[sh_cur_step];
        o.igniter_time_ms  = sh_igniter_on;
    endfunction

    function automatic void go_idle();
        sh_mode       = MODE_IDLE;
        sh_cur_step   = '0;
        sh_step_count = '0;
    endfunction

    // Advance the shadow state by one item and return the result it must produce.
    function automatic outcome_t sequence_item(input cmd_t c);
        outcome_t o;
        bit       untimed;
        o = '0;
        case (c.kind)
            KIND_ZONE_WRITE:
            begin
                sh_enabled[c.zone_index] = c.zone_enable;
                sh_order[c.zone_index]   = c.zone_order;
                sh_group[c.zone_index]   = c.zone_group;
                sh_time[c.zone_index]    = c.zone_time_ms;
            end
            KIND_START:
            begin
                if (!c.master_armed)
                    o.event_res = EV_NOT_ARMED;
                else
                begin
                    rebuild_queue();
                    untimed = 1'b0;
                    for (int i = 0; i < NZ; i++)
                        if (sh_enabled[i] && sh_time[i] == '0)
                            untimed = 1'b1;
                    if (sh_step_count == '0)
                        o.event_res = EV_EMPTY;
                    else if (untimed)
                        o.event_res = EV_NO_TIME;
                    else
                    begin
                        sh_mode     = MODE_RUNNING;
                        sh_cur_step = '0;
                        sh_elapsed  = '0;
                        fill_fire(o);
                    end
                end
            end
            KIND_TICK:
            begin
                if (sh_mode == MODE_RUNNING)
                begin
                    if (sh_elapsed != ELAPSED_SAT)
                        sh_elapsed++;
                    if (sh_cur_step >= sh_step_count)
                    begin
                        go_idle();
                        o.event_res = EV_COMPLETE;
                    end
                    else if (32'(sh_elapsed) >=
                             32'(sh_step_time[sh_cur_step]) + 32'(sh_auto_delay))
                    begin
                        sh_cur_step++;
                        if (sh_cur_step >= sh_step_count)
                        begin
                            go_idle();
                            o.event_res = EV_COMPLETE;
                        end
                        else
                        begin
                            sh_elapsed = '0;
                            fill_fire(o);
                        end
                    end
                end
            end
            KIND_ABORT:
            begin
                if (sh_mode == MODE_RUNNING)
                begin
                    sh_mode       = MODE_ABORTED;
                    sh_cur_step   = '0;
                    sh_step_count = '0;
                    o.event_res   = EV_ABORTED;
                    o.disarm      = 1'b1;
                end
            end
            KIND_STOP:
            begin
                if (sh_mode == MODE_RUNNING)
                begin
                    go_idle();
                    o.event_res = EV_STOPPED;
                end
            end
            default:
            begin
            end
        endcase
        o.run_status = sh_mode;
        return o;
    endfunction

    // Random gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: present items from the pending queue, holding valid across back-to-back items.
    int  send_gap;
    bit  hold_off;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid        <= 1'b0;
            req.kind         <= '0;
            req.zone_index   <= '0;
            req.zone_enable  <= 1'b0;
            req.zone_order   <= '0;
            req.zone_group   <= '0;
            req.zone_time_ms <= '0;
            req.master_armed <= 1'b0;
            send_gap         <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                awaited.insert(awaited.size(), sequence_item(cmd_t'({req.kind,
                    req.zone_index, req.zone_enable, req.zone_order, req.zone_group,
                    req.zone_time_ms, req.master_armed})));
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    req.valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (pending_cmds.size() > 0 && !hold_off)
                begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    req.valid        <= 1'b1;
                    req.kind         <= c.kind;
                    req.zone_index   <= c.zone_index;
                    req.zone_enable  <= c.zone_enable;
                    req.zone_order   <= c.zone_order;
                    req.zone_group   <= c.zone_group;
                    req.zone_time_ms <= c.zone_time_ms;
                    req.master_armed <= c.master_armed;
                    send_gap         <= pick_gap();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: take results with random stalls and compare each with the oldest expectation.
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall     <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                    report("unexpected result event", 32'(rsp.event_res), 32'd0);
                else
                begin
                    outcome_t w;
                    w = awaited.pop_front();
                    if (rsp.event_res !== w.event_res)
                        report("event_res", 32'(rsp.event_res), 32'(w.event_res));
                    if (rsp.fire_mask !== w.fire_mask)
                        report("fire_mask", 32'(rsp.fire_mask), 32'(w.fire_mask));
                    if (rsp.first_zone !== w.first_zone)
                        report("first_zone", 32'(rsp.first_zone), 32'(w.first_zone));
                    if (rsp.step_number !== w.step_number)
                        report("step_number", 32'(rsp.step_number), 32'(w.step_number));
                    if (rsp.total_steps !== w.total_steps)
                        report("total_steps", 32'(rsp.total_steps), 32'(w.total_steps));
                    if (rsp.step_duration_ms !== w.step_duration_ms)
                        report("step_duration_ms", 32'(rsp.step_duration_ms),
                               32'(w.step_duration_ms));
                    if (rsp.igniter_time_ms !== w.igniter_time_ms)
                        report("igniter_time_ms", 32'(rsp.igniter_time_ms),
                               32'(w.igniter_time_ms));
                    if (rsp.disarm !== w.disarm)
                        report("disarm", 32'(rsp.disarm), 32'(w.disarm));
                    if (rsp.run_status !== w.run_status)
                        report("run_status", 32'(rsp.run_status), 32'(w.run_status));
                end
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall     <= stall - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
                stall     <= pick_gap();
            end
        end
    end

    // Register writer: takes a staged write, presents it and holds busy until it is accepted.
    logic [CFG_IDX_W-1:0] cfg_idx_next;
    logic [CFG_W-1:0]     cfg_data_next;
    bit                   cfg_req;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.index <= '0;
            cfg.data  <= '0;
            cfg_busy  = 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_AUTO_DELAY)
                sh_auto_delay = cfg.data;
            else if (cfg.index == CFG_IGNITER_ON)
                sh_igniter_on = cfg.data;
            cfg.valid <= 1'b0;
            cfg_busy  = 1'b0;
        end
        else if (cfg_req && !cfg_busy)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= cfg_idx_next;
            cfg.data  <= cfg_data_next;
            cfg_busy  = 1'b1;
            cfg_req   = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic add_zone(input int z, input bit en, input int ord, input int grp, input int t);
        cmd_t c;
        c = '0;
        c.kind         = KIND_ZONE_WRITE;
        c.zone_index   = ZIDX_W'(z);
        c.zone_enable  = en;
        c.zone_order   = ORDER_W'(ord);
        c.zone_group   = GROUP_W'(grp);
        c.zone_time_ms = TIME_W'(t);
        c.master_armed = 1'($urandom_range(0, 1));
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_op(input kind_t k, input bit armed);
        cmd_t        c;
        logic [63:0] r;
        r = {$urandom, $urandom};
        c = r[$bits(cmd_t)-1:0];
        c.kind         = k;
        c.master_armed = armed;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++)
            add_op(KIND_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Wait for the queue to drain and every result to arrive, then let in-flight work settle.
    task automatic drain();
        while (pending_cmds.size() > 0 || req.valid || awaited.size() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_idx_next  = idx;
        cfg_data_next = val;
        cfg_req       = 1'b1;
        @(posedge clk);
        while (cfg_req || cfg_busy)
            @(posedge clk);
    endtask

    // Random show: a mostly well-formed zone table, a mostly armed start, then ticks with rare disruption.
    task automatic random_show(input int zones, input bit small_times);
        int tick_budget;
        int tmax;
        tmax = small_times ? 4 : 1048575;
        for (int i = 0; i < zones; i++)
        begin
            int r;
            r = $urandom_range(0, 19);
            add_zone($urandom_range(0, 15), r != 0, $urandom_range(0, 7) * (r == 1 ? 36 : 1),
                     ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3) * (r == 2 ? 85 : 1),
                     (r == 3) ? 0 : $urandom_range(1, tmax));
        end
        add_op(KIND_START, $urandom_range(0, 9) != 0);
        tick_budget = small_times ? $urandom_range(5, 40) : $urandom_range(2, 8);
        for (int i = 0; i < tick_budget; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2)
                add_op(KIND_ABORT, 1'b0);
            else if (r < 4)
                add_op(KIND_STOP, 1'b0);
            else if (r < 5)
                add_op(kind_t'($urandom_range(5, 7)), 1'b0);
            else if (r < 6)
                add_op(KIND_START, 1'b1);
            else
                add_op(KIND_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cycle_count   = 0;
        fail_count    = 0;
        hold_off      = 1'b0;
        cfg_req       = 1'b0;
        cfg_idx_next  = '0;
        cfg_data_next = '0;
        sh_enabled    = '0;
        for (int i = 0; i < NZ; i++)
        begin
            sh_order[i]     = '0;
            sh_group[i]     = '0;
            sh_time[i]      = '0;
            sh_step_mask[i] = '0;
            sh_step_time[i] = '0;
            sh_step_lead[i] = '0;
        end
        sh_step_count = '0;
        sh_cur_step   = '0;
        sh_elapsed    = '0;
        sh_mode       = MODE_IDLE;
        sh_auto_delay = '0;
        sh_igniter_on = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle-state no-ops, empty and unarmed starts, unknown kinds.
        add_op(KIND_TICK, 1'b1);
        add_op(KIND_ABORT, 1'b1);
        add_op(KIND_STOP, 1'b1);
        add_op(kind_t'(7), 1'b1);
        add_op(KIND_START, 1'b1);
        add_op(KIND_START, 1'b0);
        drain();
        write_reg(CFG_AUTO_DELAY, 16'd1);
        write_reg(CFG_IGNITER_ON, 16'hFFFF);

        // Directed: tied orders, a group with extremes, an enabled zone without time.
        add_zone(15, 1'b1, 255, 255, 20'hFFFFF);
        add_zone(3, 1'b1, 5, 0, 2);
        add_zone(1, 1'b1, 5, 7, 1);
        add_zone(9, 1'b1, 0, 7, 3);
        add_zone(0, 1'b1, 5, 0, 1);
        add_zone(4, 1'b1, 9, 0, 0);
        add_op(KIND_START, 1'b1);
        add_zone(4, 1'b0, 9, 0, 0);
        add_op(KIND_START, 1'b1);
        add_ticks(12);
        add_op(KIND_START, 1'b1);
        add_op(KIND_ABORT, 1'b0);
        add_op(KIND_TICK, 1'b0);
        add_op(KIND_START, 1'b1);
        add_op(KIND_STOP, 1'b0);
        drain();

        // Random phases with different register settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_AUTO_DELAY, 16'd0); write_reg(CFG_IGNITER_ON, 16'd0); end
                1: write_reg(CFG_AUTO_DELAY, 16'd3);
                2: write_reg(CFG_IGNITER_ON, 16'($urandom));
                3: write_reg(CFG_AUTO_DELAY, 16'hFFFF);
                4: write_reg(CFG_AUTO_DELAY, 16'd2);
                default: write_reg(CFG_IGNITER_ON, 16'hA5A5);
            endcase
            for (int s = 0; s < 5; s++)
                random_show($urandom_range(1, 10), phase != 3 && $urandom_range(0, 9) != 0);
            // Hold the sender until every result is back, once per phase.
            hold_off = 1'b1;
            while (awaited.size() > 0 || req.valid)
                @(posedge clk);
            hold_off = 1'b0;
            drain();
        end
        // Close with a stop so no long show lingers.
        add_op(KIND_STOP, 1'b0);
        drain();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
